// ===== rtl/soft_timer_bank_macros.svh =====
// ---------------------------------------------------------------------------
// soft_timer_bank assertion macros
// Concurrent check helpers clocked on clk with async reset rst_n.
// ---------------------------------------------------------------------------
`ifndef SOFT_TIMER_BANK_MACROS_SVH
`define SOFT_TIMER_BANK_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define STB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STB_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STB_ASSERT_IMP(name, ante, cons, msg)
`define STB_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/stb_pkg.sv =====
// ---------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the soft timer bank.
// ---------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

    // default geometry
    localparam int NUM_TIMERS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    // command codes on the mode port
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_START_ONCE = 3'd1;
    localparam logic [2:0] CMD_START_AUTO = 3'd2;
    localparam logic [2:0] CMD_STOP       = 3'd3;
    localparam logic [2:0] CMD_CHECK      = 3'd4;

    // operations of the shared count unit
    typedef enum logic [1:0] {
        OP_DEC,
        OP_LOAD,
        OP_CLEAR
    } alu_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_TICK_END,
        S_CMD_RD,
        S_CMD_WR,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/stb_ram.sv =====
// ---------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/stb_alu.sv =====
// ---------------------------------------------------------------------------
// stb_alu
// Shared count unit: decrement with expiry detect and reload, load, clear.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_alu #(
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  wire stb_pkg::alu_op_t       op,
    input  wire logic [COUNT_WIDTH-1:0] count_in,
    input  wire logic [COUNT_WIDTH-1:0] reload_in,
    input  wire logic                   auto_en,
    input  wire logic [COUNT_WIDTH-1:0] load_val,
    output logic      [COUNT_WIDTH-1:0] count_out,
    output logic      [COUNT_WIDTH-1:0] reload_out,
    output logic                        expire
);

    logic [COUNT_WIDTH-1:0] dec;

    assign dec = count_in - COUNT_WIDTH'(1);

    always_comb
    begin
        count_out  = count_in;
        reload_out = reload_in;
        expire     = 1'b0;
        case (op)
            stb_pkg::OP_DEC:
            begin
                // stopped timers hold at zero
                if (count_in != '0)
                begin
                    if (dec == '0)
                    begin
                        expire    = 1'b1;
                        count_out = auto_en ? reload_in : '0;
                    end
                    else
                    begin
                        count_out = dec;
                    end
                end
            end
            stb_pkg::OP_LOAD:
            begin
                count_out  = load_val;
                reload_out = load_val;
            end
            stb_pkg::OP_CLEAR:
            begin
                count_out = '0;
            end
            default:
            begin
                count_out = count_in;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/soft_timer_bank.sv =====
// A tick runs S_TICK per timer, then S_TICK_END; a bad id or unused code runs S_RESP;
// others run S_CMD_RD, S_CMD_WR. A new command is taken in the cycle done is high.
// The tick walks every timer through the one RAM port and the shared count unit.
// Results cannot be stalled by the receiver; each shows on done for one cycle.
// Reset (rst_n, async low) clears all timers through per-entry valid bits: no sweep.
// ---------------------------------------------------------------------------
// soft_timer_bank
// Bank of countdown timers with auto-reload, served by a small sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "soft_timer_bank_macros.svh"

module soft_timer_bank #(
    parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  timer_id,
    input  wire logic [31:0] period,
    output logic             done,
    output logic             expired,
    output logic             bad_id
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int W     = COUNT_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [8:0]       NUM_T9   = 9'(NUM_TIMERS);

    stb_pkg::state_t state_reg, state_next;

    logic [2:0]            cmd_reg,    cmd_next;
    logic [IDX_W-1:0]      id_reg,     id_next;
    logic [W-1:0]          per_reg,    per_next;
    logic                  bad_reg,    bad_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  wr_vld_reg, wr_vld_next;
    logic [IDX_W-1:0]      wr_idx_reg, wr_idx_next;
    logic [NUM_TIMERS-1:0] flag_reg,   flag_next;
    logic [NUM_TIMERS-1:0] auto_reg,   auto_next;
    logic [NUM_TIMERS-1:0] vld_reg,    vld_next;
    logic                  rd_vld_reg;
    logic                  done_reg,   done_next;
    logic                  exp_reg,    exp_next;

    logic                  accept;
    logic                  id_bad;
    logic                  cmd_known;

    // RAM and count unit hookup
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [2*W-1:0]        ram_wdata;
    logic [2*W-1:0]        ram_rdata;
    logic [W-1:0]          cur_count;
    logic [W-1:0]          cur_reload;
    stb_pkg::alu_op_t      alu_op;
    logic                  alu_auto;
    logic [W-1:0]          alu_count;
    logic [W-1:0]          alu_reload;
    logic                  alu_expire;

    assign busy    = (state_reg != stb_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign expired = exp_reg;
    assign bad_id  = bad_reg;

    // command decode at the input
    assign cmd_known = mode inside {stb_pkg::CMD_START_ONCE, stb_pkg::CMD_START_AUTO,
                                    stb_pkg::CMD_STOP, stb_pkg::CMD_CHECK};
    assign id_bad    = cmd_known && ({1'b0, timer_id} >= NUM_T9);

    // entries never written read as zero
    assign cur_count  = rd_vld_reg ? ram_rdata[W-1:0]   : '0;
    assign cur_reload = rd_vld_reg ? ram_rdata[2*W-1:W] : '0;
    assign ram_wdata  = {alu_reload, alu_count};

    stb_ram #(
        .WIDTH (2 * W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stb_alu #(
        .COUNT_WIDTH (W)
    ) u_alu (
        .op         (alu_op),
        .count_in   (cur_count),
        .reload_in  (cur_reload),
        .auto_en    (alu_auto),
        .load_val   (per_reg),
        .count_out  (alu_count),
        .reload_out (alu_reload),
        .expire     (alu_expire)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == stb_pkg::CMD_TICK)
                    begin
                        state_next = stb_pkg::S_TICK;
                    end
                    else if (id_bad || !cmd_known)
                    begin
                        state_next = stb_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = stb_pkg::S_CMD_RD;
                    end
                end
            end
            stb_pkg::S_TICK:
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = stb_pkg::S_TICK_END;
                end
            end
            stb_pkg::S_TICK_END: state_next = stb_pkg::S_IDLE;
            stb_pkg::S_CMD_RD:   state_next = stb_pkg::S_CMD_WR;
            stb_pkg::S_CMD_WR:   state_next = stb_pkg::S_IDLE;
            stb_pkg::S_RESP:     state_next = stb_pkg::S_IDLE;
            default:             state_next = stb_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        ram_raddr = (state_reg == stb_pkg::S_TICK) ? rd_idx_reg : id_reg;
        ram_we    = 1'b0;
        ram_waddr = id_reg;
        alu_op    = stb_pkg::OP_DEC;
        alu_auto  = auto_reg[wr_idx_reg];
        case (state_reg)
            stb_pkg::S_TICK, stb_pkg::S_TICK_END:
            begin
                // write back the timer read in the cycle before
                ram_we    = wr_vld_reg;
                ram_waddr = wr_idx_reg;
            end
            stb_pkg::S_CMD_WR:
            begin
                if (cmd_reg inside {stb_pkg::CMD_START_ONCE, stb_pkg::CMD_START_AUTO})
                begin
                    ram_we = 1'b1;
                    alu_op = stb_pkg::OP_LOAD;
                end
                else if (cmd_reg == stb_pkg::CMD_STOP)
                begin
                    ram_we = 1'b1;
                    alu_op = stb_pkg::OP_CLEAR;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // register next values
    always_comb
    begin
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        per_next    = per_reg;
        bad_next    = bad_reg;
        rd_idx_next = rd_idx_reg;
        wr_vld_next = wr_vld_reg;
        wr_idx_next = wr_idx_reg;
        flag_next   = flag_reg;
        auto_next   = auto_reg;
        vld_next    = vld_reg;
        exp_next    = exp_reg;
        done_next   = 1'b0;

        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end

        case (state_reg)
            stb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = mode;
                    id_next     = timer_id[IDX_W-1:0];
                    per_next    = period[W-1:0];
                    bad_next    = id_bad;
                    exp_next    = 1'b0;
                    rd_idx_next = '0;
                    wr_vld_next = 1'b0;
                end
            end
            stb_pkg::S_TICK:
            begin
                if (wr_vld_reg && alu_expire)
                begin
                    flag_next[wr_idx_reg] = 1'b1;
                end
                wr_vld_next = 1'b1;
                wr_idx_next = rd_idx_reg;
                if (rd_idx_reg != LAST_IDX)
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            stb_pkg::S_TICK_END:
            begin
                if (wr_vld_reg && alu_expire)
                begin
                    flag_next[wr_idx_reg] = 1'b1;
                end
                wr_vld_next = 1'b0;
                done_next   = 1'b1;
            end
            stb_pkg::S_CMD_WR:
            begin
                if (cmd_reg inside {stb_pkg::CMD_START_ONCE, stb_pkg::CMD_START_AUTO})
                begin
                    auto_next[id_reg] = (cmd_reg == stb_pkg::CMD_START_AUTO);
                end
                else if (cmd_reg == stb_pkg::CMD_STOP)
                begin
                    auto_next[id_reg] = 1'b0;
                end
                else
                begin
                    exp_next = flag_reg[id_reg];
                end
                flag_next[id_reg] = 1'b0;
                done_next         = 1'b1;
            end
            stb_pkg::S_RESP:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stb_pkg::S_IDLE;
            wr_vld_reg <= 1'b0;
            flag_reg   <= '0;
            auto_reg   <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            exp_reg    <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_vld_reg <= wr_vld_next;
            flag_reg   <= flag_next;
            auto_reg   <= auto_next;
            vld_reg    <= vld_next;
            rd_vld_reg <= vld_reg[ram_raddr];
            done_reg   <= done_next;
            exp_reg    <= exp_next;
            bad_reg    <= bad_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        per_reg    <= per_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
    end

    // checks
    `STB_ASSERT_IMP(a_done_idle, done_reg, !busy, "done strobe while busy")
    `STB_ASSERT_IMP(a_done_after_busy, done_reg, $past(busy), "done without a transaction")
    `STB_ASSERT_NXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
    `STB_ASSERT_IMP(a_done_excl, done_reg, !(exp_reg && bad_reg), "expired and bad_id together")
    `STB_ASSERT_IMP(a_wb_in_tick, wr_vld_reg,
        (state_reg == stb_pkg::S_TICK) || (state_reg == stb_pkg::S_TICK_END),
        "tick write-back outside tick walk")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives command transactions into the timer bank. A directed table comes
// first, then random bursts. A local timer model predicts each response that the table
// does not give, and each done strobe is matched against the oldest prediction.
// ---------------------------------------------------------------------------

module testbench;

    localparam int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF;
    localparam int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF;

    // mode codes the block ignores
    localparam logic [2:0] MODE_SPARE_LO = stb_pkg::CMD_CHECK + 3'd1;
    localparam logic [2:0] MODE_SPARE_HI = '1;

    localparam int RANDOM_CMDS = 1150;
    localparam int DRAIN_AT    = 400;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic expired;
        logic bad_id;
    } timer_resp_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  tid;
        logic [31:0] per;
        logic        typed;
        logic        exp_expired;
        logic        exp_bad;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    // typed rows carry a known answer; the rest go through the timer model
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{stb_pkg::CMD_CHECK,      8'd0,   32'd0,         1'b1, 1'b0, 1'b0}, // clear after reset
        '{stb_pkg::CMD_CHECK,      8'd255, 32'd0,         1'b1, 1'b0, 1'b1}, // bad id
        '{stb_pkg::CMD_START_ONCE, 8'd16,  32'd5,         1'b1, 1'b0, 1'b1}, // first bad id
        '{stb_pkg::CMD_START_AUTO, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1},
        '{stb_pkg::CMD_STOP,       8'd128, 32'd0,         1'b1, 1'b0, 1'b1},
        '{MODE_SPARE_LO,           8'd3,   32'd7,         1'b1, 1'b0, 1'b0}, // unused code
        '{MODE_SPARE_HI,           8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{stb_pkg::CMD_START_ONCE, 8'd0,   32'd1,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_START_AUTO, 8'd15,  32'd2,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_START_ONCE, 8'd3,   32'd0,         1'b0, 1'b0, 1'b0}, // zero period
        '{stb_pkg::CMD_START_AUTO, 8'd5,   32'd0,         1'b0, 1'b0, 1'b0}, // zero reload
        '{stb_pkg::CMD_START_ONCE, 8'd1,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_TICK,       8'd255, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}, // id ignored
        '{stb_pkg::CMD_TICK,       8'd0,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_CHECK,      8'd0,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_CHECK,      8'd0,   32'd0,         1'b0, 1'b0, 1'b0}, // read clears
        '{stb_pkg::CMD_CHECK,      8'd15,  32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_CHECK,      8'd3,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_CHECK,      8'd5,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_TICK,       8'd0,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_TICK,       8'd0,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_STOP,       8'd15,  32'd0,         1'b0, 1'b0, 1'b0}, // drops flag
        '{stb_pkg::CMD_CHECK,      8'd15,  32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_CHECK,      8'd1,   32'd0,         1'b0, 1'b0, 1'b0},
        '{stb_pkg::CMD_STOP,       8'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic [2:0]  mode     = stb_pkg::CMD_TICK;
    logic [7:0]  timer_id = '0;
    logic [31:0] period   = '0;
    logic        busy;
    logic        done;
    logic        expired;
    logic        bad_id;

    // timer model state
    logic [COUNT_WIDTH-1:0] model_count  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] model_reload [NUM_TIMERS];
    logic                   model_flag   [NUM_TIMERS];
    logic                   model_auto   [NUM_TIMERS];

    timer_resp_t pending_responses [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    soft_timer_bank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .timer_id (timer_id),
        .period   (period),
        .done     (done),
        .expired  (expired),
        .bad_id   (bad_id)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] ERROR: %s", $time, what);
    endtask

    // apply one command to the timer model and return its response
    function automatic timer_resp_t predict_timer_response(input logic [2:0]  cmd,
                                                           input logic [7:0]  tid,
                                                           input logic [31:0] per);
        timer_resp_t            resp;
        logic [COUNT_WIDTH-1:0] load;
        resp = '0;
        load = per[COUNT_WIDTH-1:0];
        case (cmd)
            stb_pkg::CMD_TICK:
            begin
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    if (model_count[t] != '0)
                    begin
                        model_count[t] = model_count[t] - 1'b1;
                        if (model_count[t] == '0)
                        begin
                            model_flag[t] = 1'b1;
                            if (model_auto[t])
                                model_count[t] = model_reload[t];
                        end
                    end
                end
            end
            stb_pkg::CMD_START_ONCE, stb_pkg::CMD_START_AUTO,
            stb_pkg::CMD_STOP, stb_pkg::CMD_CHECK:
            begin
                if (tid >= NUM_TIMERS)
                    resp.bad_id = 1'b1;
                else if (cmd == stb_pkg::CMD_STOP)
                begin
                    model_count[tid] = '0;
                    model_flag[tid]  = 1'b0;
                    model_auto[tid]  = 1'b0;
                end
                else if (cmd == stb_pkg::CMD_CHECK)
                begin
                    resp.expired    = model_flag[tid];
                    model_flag[tid] = 1'b0;
                end
                else
                begin
                    model_count[tid]  = load;
                    model_reload[tid] = load;
                    model_flag[tid]   = 1'b0;
                    model_auto[tid]   = (cmd == stb_pkg::CMD_START_AUTO);
                end
            end
            default: ;
        endcase
        return resp;
    endfunction

    // present one transaction, hold it until accepted, then log the prediction
    task automatic run_command(input logic [2:0]  cmd,
                               input logic [7:0]  tid,
                               input logic [31:0] per,
                               input logic        typed,
                               input logic        exp_expired,
                               input logic        exp_bad);
        timer_resp_t resp;
        start    <= 1'b1;
        mode     <= cmd;
        timer_id <= tid;
        period   <= per;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        resp = predict_timer_response(cmd, tid, per);
        if (typed)
        begin
            resp.expired = exp_expired;
            resp.bad_id  = exp_bad;
        end
        pending_responses.push_back(resp);
    endtask

    // response checker
    always @(posedge clk)
    begin
        timer_resp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response strobe with no transaction pending");
            else
            begin
                want = pending_responses.pop_front();
                if (expired !== want.expired)
                    report_mismatch($sformatf("expired %b, want %b", expired, want.expired));
                if (bad_id !== want.bad_id)
                    report_mismatch($sformatf("bad_id %b, want %b", bad_id, want.bad_id));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int          burst_left;
        int          sel;
        logic [2:0]  cmd;
        logic [7:0]  tid;
        logic [31:0] per;

        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            model_count[t]  = '0;
            model_reload[t] = '0;
            model_flag[t]   = 1'b0;
            model_auto[t]   = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            run_command(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].tid, DIRECTED_ROWS[r].per,
                        DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp_expired,
                        DIRECTED_ROWS[r].exp_bad);

        // random bursts
        burst_left = 0;
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (burst_left == 0 || i == DRAIN_AT)
            begin
                start <= 1'b0;
                if (i == DRAIN_AT)
                begin
                    // hold off until every response is back
                    do
                        @(posedge clk);
                    while (pending_responses.size() != 0);
                end
                else
                    repeat ($urandom_range(20, 1)) @(posedge clk);
                if ($urandom_range(3, 0) == 0)
                    burst_left = $urandom_range(120, 40);
                else
                    burst_left = $urandom_range(12, 1);
            end

            sel = $urandom_range(99, 0);
            if (sel < 40)
                cmd = stb_pkg::CMD_TICK;
            else if (sel < 52)
                cmd = stb_pkg::CMD_START_ONCE;
            else if (sel < 64)
                cmd = stb_pkg::CMD_START_AUTO;
            else if (sel < 72)
                cmd = stb_pkg::CMD_STOP;
            else if (sel < 95)
                cmd = stb_pkg::CMD_CHECK;
            else
                cmd = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));

            if ($urandom_range(9, 0) == 0)
                tid = 8'($urandom_range(255, NUM_TIMERS));
            else
                tid = 8'($urandom_range(NUM_TIMERS - 1, 0));

            // short periods so timers expire often; some zero, some full range
            sel = $urandom_range(9, 0);
            if (sel < 7)
                per = $urandom_range(6, 1);
            else if (sel == 7)
                per = '0;
            else if (sel == 8)
                per = $urandom_range(40, 7);
            else
                per = $urandom();

            run_command(cmd, tid, per, 1'b0, 1'b0, 1'b0);
            burst_left--;
        end
        start <= 1'b0;

        // drain, then allow one tick walk for stray strobes
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (NUM_TIMERS + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
